### hdl/ctas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctas_pkg
// Shared types and constants of the cyclic task activation scheduler.
// ----------------------------------------------------------------------------
package ctas_pkg;

  localparam int MAX_SLOTS_DEF   = 8;
  localparam int PERIOD_BITS_DEF = 16;
  localparam int LCM_W           = 32;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 16;

  localparam logic [15:0] DEFAULT_TICK_RST = 16'd1;
  localparam logic [3:0]  ACTIVE_SLOTS_RST = 4'd8;
  localparam logic [31:0] CYCLE_SAT        = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_REMOVE = 3'd1,
    OP_START  = 3'd2,
    OP_STOP   = 3'd3,
    OP_TICK   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_REFUSED    = 2'd1,
    ST_BAD_PERIOD = 2'd2,
    ST_OVERFLOW   = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEFAULT_TICK = 1'b0,
    CFG_ACTIVE_SLOTS = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [15:0] period_len;
    logic [2:0]  slot_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  assigned_slot;
    logic [7:0]  activation_mask;
    logic [15:0] microcycle_ms;
    logic [31:0] macrocycle_ticks;
    logic [31:0] tick_count;
  } out_item_t;

endpackage

### hdl/ctas_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctas_if
// Valid/ready channels for scheduler commands and results.
// ----------------------------------------------------------------------------
interface ctas_in_if;
  logic               valid;
  logic               ready;
  ctas_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ctas_out_if;
  logic                valid;
  logic                ready;
  ctas_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hdl/cyclic_task_activation_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cyclic_task_activation_scheduler
// Time-triggered cyclic executive: task slot table, schedule setup and ticks.
// ----------------------------------------------------------------------------
// Commands arrive on in_ch (add, remove, start, stop, tick); every command
// gives exactly one result item on out_ch. Configuration (default tick and
// number of slots in use) must be written on cfg_* while the block is idle;
// the block itself does not enforce this. Periods live in one RAM, tick
// periods and per-slot phase counters in a second; both are walked one slot
// at a time. Add, remove, stop and refused commands go from idle straight to
// the output stage. A tick walks all MAX_SLOTS slots and reads and writes
// back the phase counter of each slot holding a tick period. Start uses the
// shared binary GCD unit (one step per cycle, up to twice per slot) and the
// divider (up to two divisions per slot plus one).
// One command is processed at a time; in_ch.ready is high when the command
// sequencer is idle. A result waiting in the output register does not block
// the next command; a second result waits until out_ch takes the first.
// Reset (synchronous, rst_n low) empties the table, stops the scheduler and
// drops any pending result.
// ----------------------------------------------------------------------------
module cyclic_task_activation_scheduler #(
  parameter int MAX_SLOTS   = ctas_pkg::MAX_SLOTS_DEF,
  parameter int PERIOD_BITS = ctas_pkg::PERIOD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  ctas_in_if.sink                        in_ch,
  ctas_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [ctas_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [ctas_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int IW = $clog2(MAX_SLOTS + 1);
  localparam int CW = (IW > 4) ? IW : 4;
  localparam int PB = PERIOD_BITS;
  localparam int LW = ctas_pkg::LCM_W;
  localparam int SW = 2 * PB;

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_SRD  = 14'b00000000000010,
    S_SCHK = 14'b00000000000100,
    S_GCDG = 14'b00000000001000,
    S_GCDL = 14'b00000000010000,
    S_DIVL = 14'b00000000100000,
    S_MUL  = 14'b00000001000000,
    S_CYC  = 14'b00000010000000,
    S_TRD  = 14'b00000100000000,
    S_TDS  = 14'b00001000000000,
    S_TDIV = 14'b00010000000000,
    S_KRD  = 14'b00100000000000,
    S_KWR  = 14'b01000000000000,
    S_OUT  = 14'b10000000000000
  } state_t;

  state_t               state_r, state_nxt;
  logic [MAX_SLOTS-1:0] valid_r, valid_nxt;
  logic [MAX_SLOTS-1:0] tok_r, tok_nxt;
  logic                 running_r, running_nxt;
  logic [31:0]          elapsed_r, elapsed_nxt;
  logic [15:0]          tick_len_r, tick_len_nxt;
  logic [31:0]          cycle_r, cycle_nxt;
  logic [15:0]          dflt_r;
  logic [3:0]           act_r;
  logic [IW-1:0]        i_r, i_nxt;
  logic [PB-1:0]        g_r, g_nxt;
  logic [LW-1:0]        l_r, l_nxt;
  logic [PB-1:0]        p_r, p_nxt;
  logic [LW-1:0]        q_r, q_nxt;
  logic                 any_r, any_nxt;
  logic                 sat_r, sat_nxt;
  logic [1:0]           res_status_r, res_status_nxt;
  logic [2:0]           res_slot_r, res_slot_nxt;
  logic [7:0]           res_mask_r, res_mask_nxt;
  logic [31:0]          res_count_r, res_count_nxt;
  logic                 out_valid_r, out_valid_nxt;
  ctas_pkg::out_item_t  out_data_r, out_data_nxt;

  logic                 in_acc;
  logic [PB-1:0]        p_in;
  logic [IW-1:0]        n;
  logic [CW-1:0]        act_ext;
  logic [AW-1:0]        ia;
  logic                 found;
  logic [AW-1:0]        free_idx;
  logic [MAX_SLOTS-1:0] rm_vec;
  logic [LW+PB-1:0]     prod;
  logic [PB-1:0]        pt;
  logic [PB-1:0]        rem;
  logic [PB:0]          rem_inc;

  logic                 per_we;
  logic [PB-1:0]        per_rdata;
  logic                 sch_we;
  logic [SW-1:0]        sch_wdata;
  logic [SW-1:0]        sch_rdata;

  logic                 gcd_start, gcd_done;
  logic [LW-1:0]        gcd_a, gcd_b, gcd_res;
  logic                 div_start, div_done;
  logic [LW-1:0]        div_a, div_q;
  logic [PB-1:0]        div_b;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign p_in        = PB'(in_ch.data.period_len);
  assign act_ext     = CW'(act_r);
  assign n           = (act_ext > CW'(MAX_SLOTS)) ? IW'(MAX_SLOTS) : IW'(act_ext);
  assign ia          = i_r[AW-1:0];
  assign prod        = q_r * p_r;
  assign pt          = sch_rdata[SW-1:PB];
  assign rem         = sch_rdata[PB-1:0];
  assign rem_inc     = {1'b0, rem} + 1'b1;

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // first free slot below the slot count
  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int j = MAX_SLOTS - 1; j >= 0; j--) begin
      if (!valid_r[j] && (j < n)) begin
        found    = 1'b1;
        free_idx = AW'(j);
      end
    end
  end

  always_comb begin
    for (int j = 0; j < MAX_SLOTS; j++) begin
      rm_vec[j] = (j == in_ch.data.slot_index) && (j < n) && valid_r[j];
    end
  end

  ctas_ram #(.W(PB), .D(MAX_SLOTS)) u_per_ram (
    .clk   (clk),
    .we    (per_we),
    .waddr (free_idx),
    .wdata (p_in),
    .raddr (ia),
    .rdata (per_rdata)
  );

  ctas_ram #(.W(SW), .D(MAX_SLOTS)) u_sch_ram (
    .clk   (clk),
    .we    (sch_we),
    .waddr (ia),
    .wdata (sch_wdata),
    .raddr (ia),
    .rdata (sch_rdata)
  );

  ctas_gcd #(.W(LW)) u_gcd (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (gcd_start),
    .a      (gcd_a),
    .b      (gcd_b),
    .done   (gcd_done),
    .result (gcd_res)
  );

  ctas_div #(.NW(LW), .DW(PB)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    tok_nxt        = tok_r;
    running_nxt    = running_r;
    elapsed_nxt    = elapsed_r;
    tick_len_nxt   = tick_len_r;
    cycle_nxt      = cycle_r;
    i_nxt          = i_r;
    g_nxt          = g_r;
    l_nxt          = l_r;
    p_nxt          = p_r;
    q_nxt          = q_r;
    any_nxt        = any_r;
    sat_nxt        = sat_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_mask_nxt   = res_mask_r;
    res_count_nxt  = res_count_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_data_nxt   = out_data_r;
    per_we         = 1'b0;
    sch_we         = 1'b0;
    sch_wdata      = '0;
    gcd_start      = 1'b0;
    gcd_a          = '0;
    gcd_b          = '0;
    div_start      = 1'b0;
    div_a          = '0;
    div_b          = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_status_nxt = ctas_pkg::ST_OK;
          res_slot_nxt   = '0;
          res_mask_nxt   = '0;
          res_count_nxt  = elapsed_r;
          state_nxt      = S_OUT;
          case (in_ch.data.operation)
            ctas_pkg::OP_ADD: begin
              running_nxt = 1'b0;
              if (p_in == '0) begin
                res_status_nxt = ctas_pkg::ST_BAD_PERIOD;
              end else if (!found) begin
                res_status_nxt = ctas_pkg::ST_REFUSED;
              end else begin
                valid_nxt[free_idx] = 1'b1;
                per_we              = 1'b1;
                res_slot_nxt        = 3'(free_idx);
              end
            end
            ctas_pkg::OP_REMOVE: begin
              running_nxt = 1'b0;
              if (rm_vec != '0) begin
                valid_nxt = valid_r & ~rm_vec;
              end else begin
                res_status_nxt = ctas_pkg::ST_REFUSED;
              end
            end
            ctas_pkg::OP_START: begin
              if (running_r) begin
                res_status_nxt = ctas_pkg::ST_REFUSED;
              end else begin
                i_nxt     = '0;
                any_nxt   = 1'b0;
                sat_nxt   = 1'b0;
                state_nxt = S_SRD;
              end
            end
            ctas_pkg::OP_STOP: begin
              if (running_r) begin
                running_nxt = 1'b0;
              end else begin
                res_status_nxt = ctas_pkg::ST_REFUSED;
              end
            end
            ctas_pkg::OP_TICK: begin
              if (!running_r) begin
                res_status_nxt = ctas_pkg::ST_REFUSED;
              end else begin
                i_nxt     = '0;
                state_nxt = S_KRD;
              end
            end
            default: begin
              res_status_nxt = ctas_pkg::ST_REFUSED;
            end
          endcase
        end
      end

      // GCD / LCM pass over the valid slots
      S_SRD: begin
        if (i_r == n) begin
          tok_nxt = '0;
          i_nxt   = '0;
          if (!any_r) begin
            tick_len_nxt   = dflt_r;
            cycle_nxt      = '0;
            elapsed_nxt    = '0;
            running_nxt    = 1'b1;
            res_status_nxt = ctas_pkg::ST_OK;
            res_count_nxt  = '0;
            state_nxt      = S_OUT;
          end else if (sat_r) begin
            cycle_nxt = ctas_pkg::CYCLE_SAT;
            state_nxt = S_TRD;
          end else begin
            div_start = 1'b1;
            div_a     = l_r;
            div_b     = g_r;
            state_nxt = S_CYC;
          end
        end else if (valid_r[ia]) begin
          state_nxt = S_SCHK;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end

      S_SCHK: begin
        p_nxt = per_rdata;
        if (!any_r) begin
          g_nxt     = per_rdata;
          l_nxt     = LW'(per_rdata);
          any_nxt   = 1'b1;
          i_nxt     = i_r + 1'b1;
          state_nxt = S_SRD;
        end else begin
          gcd_start = 1'b1;
          gcd_a     = LW'(g_r);
          gcd_b     = LW'(per_rdata);
          state_nxt = S_GCDG;
        end
      end

      S_GCDG: begin
        if (gcd_done) begin
          g_nxt = PB'(gcd_res);
          if (sat_r) begin
            i_nxt     = i_r + 1'b1;
            state_nxt = S_SRD;
          end else begin
            gcd_start = 1'b1;
            gcd_a     = l_r;
            gcd_b     = LW'(p_r);
            state_nxt = S_GCDL;
          end
        end
      end

      S_GCDL: begin
        if (gcd_done) begin
          div_start = 1'b1;
          div_a     = l_r;
          div_b     = PB'(gcd_res);
          state_nxt = S_DIVL;
        end
      end

      S_DIVL: begin
        if (div_done) begin
          q_nxt     = div_q;
          state_nxt = S_MUL;
        end
      end

      S_MUL: begin
        if (prod[LW+PB-1:LW] != '0) begin
          sat_nxt = 1'b1;
        end else begin
          l_nxt = prod[LW-1:0];
        end
        i_nxt     = i_r + 1'b1;
        state_nxt = S_SRD;
      end

      S_CYC: begin
        if (div_done) begin
          cycle_nxt = div_q;
          state_nxt = S_TRD;
        end
      end

      // per-slot tick periods, then go running
      S_TRD: begin
        if (i_r == n) begin
          tick_len_nxt   = 16'(g_r);
          elapsed_nxt    = '0;
          running_nxt    = 1'b1;
          res_status_nxt = sat_r ? ctas_pkg::ST_OVERFLOW : ctas_pkg::ST_OK;
          res_count_nxt  = '0;
          state_nxt      = S_OUT;
        end else if (valid_r[ia]) begin
          state_nxt = S_TDS;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end

      S_TDS: begin
        div_start = 1'b1;
        div_a     = LW'(per_rdata);
        div_b     = g_r;
        state_nxt = S_TDIV;
      end

      S_TDIV: begin
        if (div_done) begin
          sch_we      = 1'b1;
          sch_wdata   = {PB'(div_q), PB'(0)};
          tok_nxt[ia] = 1'b1;
          i_nxt       = i_r + 1'b1;
          state_nxt   = S_TRD;
        end
      end

      // tick: every slot with a tick period advances its phase counter
      S_KRD: begin
        if (i_r == IW'(MAX_SLOTS)) begin
          res_status_nxt = ctas_pkg::ST_OK;
          res_count_nxt  = elapsed_r;
          elapsed_nxt    = elapsed_r + 1'b1;
          state_nxt      = S_OUT;
        end else if (tok_r[ia]) begin
          state_nxt = S_KWR;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end

      S_KWR: begin
        if ((rem == '0) && (i_r < n)) begin
          for (int b = 0; b < 8; b++) begin
            if (b == i_r) begin
              res_mask_nxt[b] = 1'b1;
            end
          end
        end
        sch_we = 1'b1;
        // counter wrap restarts every phase at zero
        if ((elapsed_r == 32'hFFFF_FFFF) || (rem_inc == {1'b0, pt})) begin
          sch_wdata = {pt, PB'(0)};
        end else begin
          sch_wdata = {pt, rem_inc[PB-1:0]};
        end
        i_nxt     = i_r + 1'b1;
        state_nxt = S_KRD;
      end

      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt                 = 1'b1;
          out_data_nxt.status           = res_status_r;
          out_data_nxt.assigned_slot    = res_slot_r;
          out_data_nxt.activation_mask  = res_mask_r;
          out_data_nxt.microcycle_ms    = tick_len_r;
          out_data_nxt.macrocycle_ticks = cycle_r;
          out_data_nxt.tick_count       = res_count_r;
          state_nxt                     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dflt_r <= ctas_pkg::DEFAULT_TICK_RST;
      act_r  <= ctas_pkg::ACTIVE_SLOTS_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        ctas_pkg::CFG_DEFAULT_TICK: dflt_r <= cfg_wdata[15:0];
        ctas_pkg::CFG_ACTIVE_SLOTS: act_r  <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      tok_r       <= '0;
      running_r   <= 1'b0;
      elapsed_r   <= '0;
      tick_len_r  <= ctas_pkg::DEFAULT_TICK_RST;
      cycle_r     <= '0;
      i_r         <= '0;
      any_r       <= 1'b0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      tok_r       <= tok_nxt;
      running_r   <= running_nxt;
      elapsed_r   <= elapsed_nxt;
      tick_len_r  <= tick_len_nxt;
      cycle_r     <= cycle_nxt;
      i_r         <= i_nxt;
      any_r       <= any_nxt;
      sat_r       <= sat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    g_r          <= g_nxt;
    l_r          <= l_nxt;
    p_r          <= p_nxt;
    q_r          <= q_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_mask_r   <= res_mask_nxt;
    res_count_r  <= res_count_nxt;
    out_data_r   <= out_data_nxt;
  end

endmodule

### hdl/ctas_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctas_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ctas_ram #(
  parameter int W = 8,
  parameter int D = 8
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                         wdata,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                         rdata
);

  logic [W-1:0] mem_r [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hdl/ctas_gcd.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctas_gcd
// Binary GCD, one subtract-or-shift step per cycle. Operands must be nonzero.
// ----------------------------------------------------------------------------
module ctas_gcd #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         done,
  output logic [W-1:0] result
);

  localparam int KW = $clog2(W) + 1;

  logic          busy_r;
  logic          done_r;
  logic [W-1:0]  a_r;
  logic [W-1:0]  b_r;
  logic [KW-1:0] k_r;
  logic [W-1:0]  res_r;
  logic          fin;

  assign fin = (a_r == '0) || (b_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && fin) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
      k_r <= '0;
    end else if (busy_r) begin
      if (fin) begin
        res_r <= (a_r | b_r) << k_r;
      end else if (!a_r[0] && !b_r[0]) begin
        a_r <= a_r >> 1;
        b_r <= b_r >> 1;
        k_r <= k_r + 1'b1;
      end else if (!a_r[0]) begin
        a_r <= a_r >> 1;
      end else if (!b_r[0]) begin
        b_r <= b_r >> 1;
      end else if (a_r >= b_r) begin
        a_r <= (a_r - b_r) >> 1;
      end else begin
        b_r <= (b_r - a_r) >> 1;
      end
    end
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

### hdl/ctas_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctas_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ctas_div #(
  parameter int NW = 32,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);

  localparam int CNTW = $clog2(NW + 1);

  logic            busy_r;
  logic            done_r;
  logic [CNTW-1:0] cnt_r;
  logic [DW-1:0]   rem_r;
  logic [NW-1:0]   quo_r;
  logic [DW-1:0]   dvs_r;
  logic [DW:0]     trial;
  logic [DW:0]     diff;
  logic            ge;

  assign trial = {rem_r, quo_r[NW-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
      quo_r <= {quo_r[NW-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### hdl/ctas_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctas_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module ctas_port_props (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input ctas_pkg::out_item_t out_data
);

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one command at a time
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("command taken while busy");

  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // only a successful command carries an activation mask
  a_mask_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.activation_mask != 8'd0) |->
      out_data.status == ctas_pkg::ST_OK)
    else $error("activation mask on a failed command");

endmodule

bind cyclic_task_activation_scheduler ctas_port_props u_ctas_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
